>>> sv/erg_pkg.sv
// Shared constants and types for the euclidean rhythm generator.
`timescale 1ns / 1ps

package erg_pkg;

    // Fixed field widths
    localparam int CNT_W        = 7;
    localparam int ROT_W        = 16;
    localparam int IDX_W        = 6;
    localparam int MAX_STEPS_DEF = 64;

    // Group lengths and counts handed from the group builder to the pattern unit
    typedef struct packed {
        logic [CNT_W-1:0] f_len;
        logic [CNT_W-1:0] f_cnt;
        logic [CNT_W-1:0] s_len;
        logic [CNT_W-1:0] s_cnt;
    } t_grp_info;

    // Sequencer commands to the pattern unit
    typedef struct packed {
        logic start;
        logic advance;
        logic finish;
    } t_pat_ctl;

    // Pattern unit status back to the sequencer
    typedef struct packed {
        logic ready;
        logic onset;
    } t_pat_sts;

endpackage

>>> sv/erg_mod.sv
// Bit-serial reduction of the signed rotation modulo the step count.
`timescale 1ns / 1ps

module erg_mod (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [15:0]        i_rot,
    input  logic [6:0]                i_steps,
    output logic                      o_done,
    output logic [5:0]                o_shift
);
    import erg_pkg::*;

    logic [ROT_W-1:0] r_sr, n_sr;
    logic [IDX_W-1:0] r_rem, n_rem;
    logic [4:0]       r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic [CNT_W-1:0] v_dbl;
    logic [CNT_W-1:0] v_init;

    // Horner step: remainder = 2*remainder + next bit, one compare and subtract
    always_comb begin
        n_sr   = r_sr;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        v_dbl  = {r_rem, r_sr[ROT_W-1]};
        v_init = i_steps - CNT_W'(1);
        if (i_start) begin
            // sign bit weighs -2^15: start from (-1) mod steps
            n_rem  = i_rot[ROT_W-1] ? v_init[IDX_W-1:0] : '0;
            n_sr   = i_rot;
            n_cnt  = 5'(ROT_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem  = (v_dbl >= i_steps) ? IDX_W'(v_dbl - i_steps) : v_dbl[IDX_W-1:0];
            n_sr   = {r_sr[ROT_W-2:0], 1'b0};
            n_cnt  = r_cnt - 5'd1;
            if (r_cnt == 5'd1) begin
                n_busy = 1'b0;
            end
        end
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_rem  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
            r_rem  <= n_rem;
        end
        r_sr <= n_sr;
    end

    assign o_done  = !r_busy;
    assign o_shift = r_rem;

endmodule

>>> sv/erg_groups.sv
// Bjorklund group builder: serial pairwise interleave of two group kinds.
`timescale 1ns / 1ps

module erg_groups #(
    parameter int MAX_STEPS = erg_pkg::MAX_STEPS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [6:0]            i_pulses,
    input  logic [6:0]            i_steps,
    output logic                  o_done,
    output logic [MAX_STEPS-1:0]  o_first_bits,
    output logic [MAX_STEPS-1:0]  o_second_bits,
    output erg_pkg::t_grp_info    o_info
);
    import erg_pkg::*;

    localparam logic [1:0] GP_IDLE  = 2'd0;
    localparam logic [1:0] GP_CHECK = 2'd1;
    localparam logic [1:0] GP_PASS  = 2'd2;

    logic [1:0]           r_phase, n_phase;
    logic [MAX_STEPS-1:0] r_f_bits, n_f_bits;
    logic [MAX_STEPS-1:0] r_s_bits, n_s_bits;
    logic [MAX_STEPS-1:0] r_ws, n_ws;
    logic [MAX_STEPS-1:0] r_m, n_m;
    logic [CNT_W-1:0]     r_f_len, n_f_len;
    logic [CNT_W-1:0]     r_f_cnt, n_f_cnt;
    logic [CNT_W-1:0]     r_s_len, n_s_len;
    logic [CNT_W-1:0]     r_s_cnt, n_s_cnt;
    logic [CNT_W-1:0]     r_k, n_k;
    logic [CNT_W-1:0]     v_mlen;
    logic                 v_bit;
    logic [MAX_STEPS-1:0] v_m;
    logic [MAX_STEPS-1:0] v_f;

    // Merge pass: stream first group then second group into the accumulator,
    // one bit per cycle; the first group rotates a full turn and comes back intact
    always_comb begin
        n_phase  = r_phase;
        n_f_bits = r_f_bits;
        n_s_bits = r_s_bits;
        n_ws     = r_ws;
        n_m      = r_m;
        n_f_len  = r_f_len;
        n_f_cnt  = r_f_cnt;
        n_s_len  = r_s_len;
        n_s_cnt  = r_s_cnt;
        n_k      = r_k;
        v_mlen   = r_f_len + r_s_len;
        v_bit    = (r_k < r_f_len) ? r_f_bits[0] :
                   ((r_k < v_mlen) ? r_ws[0] : 1'b0);
        v_m      = {v_bit, r_m[MAX_STEPS-1:1]};
        v_f      = {r_f_bits[0], r_f_bits[MAX_STEPS-1:1]};
        case (r_phase)
            GP_IDLE: begin
                if (i_start) begin
                    n_phase = GP_CHECK;
                    if (i_pulses == '0 || i_pulses == i_steps) begin
                        // all rests or all onsets: one group kind only
                        n_f_bits = {{(MAX_STEPS-1){1'b0}}, (i_pulses != '0)};
                        n_f_len  = CNT_W'(1);
                        n_f_cnt  = i_steps;
                        n_s_bits = '0;
                        n_s_len  = '0;
                        n_s_cnt  = '0;
                    end else begin
                        n_f_bits = MAX_STEPS'(1);
                        n_f_len  = CNT_W'(1);
                        n_f_cnt  = i_pulses;
                        n_s_bits = '0;
                        n_s_len  = CNT_W'(1);
                        n_s_cnt  = i_steps - i_pulses;
                    end
                end
            end
            GP_CHECK: begin
                // stop once at most one trailing group remains
                if (r_s_cnt > CNT_W'(1)) begin
                    n_phase = GP_PASS;
                    n_k     = '0;
                    n_ws    = r_s_bits;
                    n_m     = '0;
                end else begin
                    n_phase = GP_IDLE;
                end
            end
            GP_PASS: begin
                n_m      = v_m;
                n_f_bits = v_f;
                n_k      = r_k + CNT_W'(1);
                if (r_k >= r_f_len) begin
                    n_ws = r_ws >> 1;
                end
                if (r_k == CNT_W'(MAX_STEPS-1)) begin
                    if (r_f_cnt > r_s_cnt) begin
                        // leftover first groups become the trailing kind
                        n_s_bits = v_f;
                        n_s_len  = r_f_len;
                        n_s_cnt  = r_f_cnt - r_s_cnt;
                        n_f_cnt  = r_s_cnt;
                    end else begin
                        n_s_cnt  = r_s_cnt - r_f_cnt;
                    end
                    n_f_bits = v_m;
                    n_f_len  = v_mlen;
                    n_phase  = GP_CHECK;
                end
            end
            default: begin
                n_phase = GP_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= GP_IDLE;
            r_f_bits <= '0;
            r_s_bits <= '0;
            r_f_len  <= '0;
            r_f_cnt  <= '0;
            r_s_len  <= '0;
            r_s_cnt  <= '0;
            r_k      <= '0;
        end else begin
            r_phase  <= n_phase;
            r_f_bits <= n_f_bits;
            r_s_bits <= n_s_bits;
            r_f_len  <= n_f_len;
            r_f_cnt  <= n_f_cnt;
            r_s_len  <= n_s_len;
            r_s_cnt  <= n_s_cnt;
            r_k      <= n_k;
        end
        r_ws <= n_ws;
        r_m  <= n_m;
    end

    assign o_done        = (r_phase == GP_IDLE);
    assign o_first_bits  = r_f_bits;
    assign o_second_bits = r_s_bits;
    assign o_info        = '{f_len: r_f_len, f_cnt: r_f_cnt,
                             s_len: r_s_len, s_cnt: r_s_cnt};

endmodule

>>> sv/erg_pattern.sv
// Pattern shift register: flatten groups, rotate within the step count, emit.
`timescale 1ns / 1ps

module erg_pattern #(
    parameter int MAX_STEPS = erg_pkg::MAX_STEPS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  erg_pkg::t_pat_ctl     i_ctl,
    input  logic [MAX_STEPS-1:0]  i_first_bits,
    input  logic [MAX_STEPS-1:0]  i_second_bits,
    input  erg_pkg::t_grp_info    i_info,
    input  logic [6:0]            i_steps,
    input  logic [5:0]            i_shift,
    output erg_pkg::t_pat_sts     o_sts
);
    import erg_pkg::*;

    localparam logic [1:0] PT_IDLE = 2'd0;
    localparam logic [1:0] PT_FLAT = 2'd1;
    localparam logic [1:0] PT_ROT  = 2'd2;
    localparam logic [1:0] PT_EMIT = 2'd3;

    logic [1:0]           r_phase, n_phase;
    logic [MAX_STEPS-1:0] r_p, n_p;
    logic [MAX_STEPS-1:0] r_w, n_w;
    logic [CNT_W-1:0]     r_k, n_k;
    logic [CNT_W-1:0]     r_j, n_j;
    logic [CNT_W-1:0]     r_c, n_c;
    logic                 r_g, n_g;
    logic [IDX_W-1:0]     r_cnt, n_cnt;
    logic [CNT_W-1:0]     v_len;
    logic                 v_bit;
    logic [MAX_STEPS-1:0] v_shr;
    logic [MAX_STEPS-1:0] v_rot;

    // Rotate right inside the first i_steps bits: bit 0 wraps to bit steps-1
    always_comb begin
        v_shr = r_p >> 1;
        for (int b = 0; b < MAX_STEPS; b++) begin
            v_rot[b] = (CNT_W'(b) == i_steps - CNT_W'(1)) ? r_p[0] : v_shr[b];
        end
    end

    // Flatten, pre-rotate and emit sequencing
    always_comb begin
        n_phase = r_phase;
        n_p     = r_p;
        n_w     = r_w;
        n_k     = r_k;
        n_j     = r_j;
        n_c     = r_c;
        n_g     = r_g;
        n_cnt   = r_cnt;
        v_len   = r_g ? i_info.s_len : i_info.f_len;
        v_bit   = (r_k < i_steps) ? r_w[0] : 1'b0;
        case (r_phase)
            PT_IDLE: begin
                if (i_ctl.start) begin
                    n_phase = PT_FLAT;
                    n_k     = '0;
                    n_j     = '0;
                    n_c     = '0;
                    n_g     = 1'b0;
                    n_w     = i_first_bits;
                    n_p     = '0;
                end
            end
            PT_FLAT: begin
                // shift one pattern bit in from the top per cycle
                n_p = {v_bit, r_p[MAX_STEPS-1:1]};
                if (r_j == v_len - CNT_W'(1)) begin
                    n_j = '0;
                    if (!r_g && r_c == i_info.f_cnt - CNT_W'(1)) begin
                        n_g = 1'b1;
                        n_c = '0;
                        n_w = i_second_bits;
                    end else begin
                        n_c = r_c + CNT_W'(1);
                        n_w = r_g ? i_second_bits : i_first_bits;
                    end
                end else begin
                    n_j = r_j + CNT_W'(1);
                    n_w = r_w >> 1;
                end
                n_k = r_k + CNT_W'(1);
                if (r_k == CNT_W'(MAX_STEPS-1)) begin
                    n_cnt   = i_shift;
                    n_phase = (i_shift != '0) ? PT_ROT : PT_EMIT;
                end
            end
            PT_ROT: begin
                n_p   = v_rot;
                n_cnt = r_cnt - IDX_W'(1);
                if (r_cnt == IDX_W'(1)) begin
                    n_phase = PT_EMIT;
                end
            end
            PT_EMIT: begin
                if (i_ctl.advance) begin
                    n_p = v_rot;
                end
                if (i_ctl.finish) begin
                    n_phase = PT_IDLE;
                end
            end
            default: begin
                n_phase = PT_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PT_IDLE;
            r_k     <= '0;
            r_j     <= '0;
            r_c     <= '0;
            r_g     <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_phase <= n_phase;
            r_k     <= n_k;
            r_j     <= n_j;
            r_c     <= n_c;
            r_g     <= n_g;
            r_cnt   <= n_cnt;
        end
        r_p <= n_p;
        r_w <= n_w;
    end

    assign o_sts = '{ready: (r_phase == PT_EMIT), onset: r_p[0]};

endmodule

>>> sv/euclidean_rhythm_generator.sv
// Euclidean rhythm generator top level: request checks, sequencing, result port.
// Usage:
//   Input channel (i_valid / o_ready) transfers one request: i_pulses, i_steps,
//   i_rotation (signed). Output channel (o_valid / i_ready) transfers one result
//   per step: o_onset, o_step_index, o_last, o_invalid.
//   One request is in flight at a time; o_ready is high only while idle, so the
//   next request is taken the cycle after the last result of the previous one.
//   A rejected request (steps zero, above MAX_STEPS, or pulses above steps)
//   yields one result with o_invalid and o_last set, in the cycle after the transfer.
//   A valid request: a load state, then a build phase that ends when both the
//   interleave rounds (0 to steps-2 of them, each a check and a MAX_STEPS-bit
//   merge pass) and the rotation reduction running alongside are done; then a
//   flatten pass and R rotate steps (R = rotation mod steps). Results then
//   transfer one per cycle while the receiver accepts them.
//   Merges and flatten shift one bit per cycle through MAX_STEPS-bit registers.
//   When the receiver stalls the current result is held and nothing advances.
//   Reset returns all sequencing to idle; no result is pending after reset.
`timescale 1ns / 1ps

module euclidean_rhythm_generator #(
    parameter int MAX_STEPS = erg_pkg::MAX_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [6:0]         i_pulses,
    input  logic [6:0]         i_steps,
    input  logic signed [15:0] i_rotation,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_onset,
    output logic [5:0]         o_step_index,
    output logic               o_last,
    output logic               o_invalid
);
    import erg_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOAD   = 3'd1;
    localparam logic [2:0] ST_BUILD  = 3'd2;
    localparam logic [2:0] ST_EMIT   = 3'd3;
    localparam logic [2:0] ST_REJECT = 3'd4;

    logic [2:0]              r_state, n_state;
    logic [CNT_W-1:0]        r_pulses;
    logic [CNT_W-1:0]        r_steps;
    logic signed [ROT_W-1:0] r_rot;
    logic [IDX_W-1:0]        r_idx, n_idx;
    logic                    w_in_xfer;
    logic                    w_out_xfer;
    logic                    w_bad;
    logic                    w_last;
    logic                    w_grp_done;
    logic                    w_mod_done;
    logic [IDX_W-1:0]        w_shift;
    logic [MAX_STEPS-1:0]    w_first_bits;
    logic [MAX_STEPS-1:0]    w_second_bits;
    t_grp_info               w_info;
    t_pat_ctl                w_ctl;
    t_pat_sts                w_sts;

    assign w_in_xfer  = i_valid & o_ready;
    assign w_out_xfer = o_valid & i_ready;
    assign w_bad      = (i_steps == '0) || (i_steps > CNT_W'(MAX_STEPS)) ||
                        (i_pulses > i_steps);
    assign w_last     = (r_state == ST_REJECT) ||
                        ({1'b0, r_idx} == r_steps - CNT_W'(1));

    // Drive pattern unit commands
    always_comb begin
        w_ctl.start   = (r_state == ST_BUILD) && w_grp_done && w_mod_done;
        w_ctl.advance = (r_state == ST_EMIT) && w_out_xfer;
        w_ctl.finish  = (r_state == ST_EMIT) && w_out_xfer && w_last;
    end

    // Sequence one request at a time
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        case (r_state)
            ST_IDLE: begin
                n_idx = '0;
                if (w_in_xfer) begin
                    n_state = w_bad ? ST_REJECT : ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_state = ST_BUILD;
            end
            ST_BUILD: begin
                if (w_grp_done && w_mod_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_out_xfer) begin
                    n_idx = r_idx + IDX_W'(1);
                    if (w_last) begin
                        n_state = ST_IDLE;
                        n_idx   = '0;
                    end
                end
            end
            ST_REJECT: begin
                if (w_out_xfer) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold control state; capture request fields on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
        if (w_in_xfer) begin
            r_pulses <= i_pulses;
            r_steps  <= i_steps;
            r_rot    <= i_rotation;
        end
    end

    erg_groups #(
        .MAX_STEPS (MAX_STEPS)
    ) u_groups (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (r_state == ST_LOAD),
        .i_pulses      (r_pulses),
        .i_steps       (r_steps),
        .o_done        (w_grp_done),
        .o_first_bits  (w_first_bits),
        .o_second_bits (w_second_bits),
        .o_info        (w_info)
    );

    erg_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_LOAD),
        .i_rot   (r_rot),
        .i_steps (r_steps),
        .o_done  (w_mod_done),
        .o_shift (w_shift)
    );

    erg_pattern #(
        .MAX_STEPS (MAX_STEPS)
    ) u_pattern (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .i_first_bits  (w_first_bits),
        .i_second_bits (w_second_bits),
        .i_info        (w_info),
        .i_steps       (r_steps),
        .i_shift       (w_shift),
        .o_sts         (w_sts)
    );

    // Result port
    assign o_ready      = (r_state == ST_IDLE);
    assign o_valid      = (r_state == ST_REJECT) || ((r_state == ST_EMIT) && w_sts.ready);
    assign o_onset      = (r_state == ST_REJECT) ? 1'b0 : w_sts.onset;
    assign o_step_index = r_idx;
    assign o_last       = w_last;
    assign o_invalid    = (r_state == ST_REJECT);

`ifndef SYNTHESIS
    a_reject_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_invalid) |-> (o_last && !o_onset && o_step_index == '0))
        else $error("rejected request result malformed");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid)
        else $error("result pending while taking a request");

    a_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_last) |=> o_valid)
        else $error("gap inside a result burst");

    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last) |=> o_ready)
        else $error("not idle after last transfer");

    a_build_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.start |-> (w_grp_done && w_mod_done))
        else $error("pattern started before groups and shift settled");
`endif

endmodule
